[rtl/sorted_key_count_table_unit_defines.svh]
// assertion macros shared by the sorted key count table rtl
`ifndef SORTED_KEY_COUNT_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEY_COUNT_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define SKTC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk outside reset
`define SKTC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sktc_pkg.sv]
// package: sizes, types and codes of the sorted key count table
package sktc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int NUM_TABLES  = 2;
  localparam int KEY_W       = 64;
  localparam int CNT_W       = 16;
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
  localparam int POS_OUT_W   = 10;
  localparam int FILL_OUT_W  = 11;
  localparam int OUTCOME_W   = 2;

  // cells are encoded in groups, then the groups are encoded
  localparam int GRP_SIZE = (TABLE_DEPTH < 32) ? TABLE_DEPTH : 32;
  localparam int NUM_GRP  = (TABLE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int LOC_W    = (GRP_SIZE > 1) ? $clog2(GRP_SIZE) : 1;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [LOC_W-1:0]  loc_t;

  localparam cnt_t CNT_MAX = '1;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_COUNTED  = 2'd0,
    OUT_INSERTED = 2'd1,
    OUT_DROPPED  = 2'd2
  } sktc_outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_GRP,
    ST_SEL,
    ST_UPD
  } sktc_state_t;

  typedef enum logic [1:0] {
    CELL_OP_HOLD,
    CELL_OP_COUNT,
    CELL_OP_INSERT
  } cell_op_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic     cmp;
    cell_op_t op;
    logic     tsel;
    key_t     key;
  } cell_cmd_t;

  // one table slot as seen by the neighbor and the encoder
  typedef struct packed {
    key_t key;
    cnt_t cnt;
  } entry_t;

  // registered summary of one group of cells
  typedef struct packed {
    logic all_lt;
    loc_t loc;
    logic eq_any;
    cnt_t cnt;
  } grp_sum_t;

endpackage

[rtl/sktc_if.sv]
// stream interfaces of the sorted key count table: request and result channels
interface sktc_in_if import sktc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       table_select;
  logic [KEY_W-1:0] key;

  modport source (output valid, output table_select, output key, input ready);
  modport sink   (input valid, input table_select, input key, output ready);
endinterface

interface sktc_out_if import sktc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUTCOME_W-1:0]  outcome;
  logic [POS_OUT_W-1:0]  entry_position;
  logic [CNT_W-1:0]      entry_count;
  logic [FILL_OUT_W-1:0] table_fill;

  modport source (output valid, output outcome, output entry_position,
                  output entry_count, output table_fill, input ready);
  modport sink   (input valid, input outcome, input entry_position,
                  input entry_count, input table_fill, output ready);
endinterface

[rtl/sorted_key_count_table_unit.sv]
// top level: controller, row of cells, group encoders and result register
//
// Two sorted tables of TABLE_DEPTH keys, each with a saturating 16-bit count
// per key, held in one row of cells (a cell keeps the same slot of both
// tables). A transaction reaches the result register through the compare,
// group, select and update states after it is accepted: every cell compares
// its key with the broadcast key, groups of 32 cells encode the first slot at
// or above the key, the group results are combined, and then all cells count
// or shift up by one together. The next request is accepted in the cycle
// after the update, so no new request is taken while one is in flight. The
// update waits while the result register still holds an untaken result.
// outcome is 0 for a counted key, 1 for an inserted key and 2 for a key
// dropped from a full table, which reports position and count as zero. Reset
// clears the two fill counts, the state, the result valid flag and the cell
// compare flags; there is no clearing pass and the block is ready at once.
module sorted_key_count_table_unit import sktc_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  sktc_in_if.sink    in_chan,
  sktc_out_if.source out_chan
);

  sktc_state_t state_r, state_nxt;
  cell_cmd_t   cmd;
  logic        upd_go;
  logic        in_acc;

  key_t  key_r;
  logic  tsel_r;
  fill_t fill_sel_r;
  fill_t fill_r [NUM_TABLES];

  entry_t                 cell_entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_lt;
  logic [TABLE_DEPTH-1:0] cell_eq;
  logic [TABLE_DEPTH-1:0] cell_in_range;
  grp_sum_t               grp_sum [NUM_GRP];

  fill_t sel_pos;
  logic  sel_eq;
  cnt_t  sel_cnt;
  logic  sel_full;

  sktc_outcome_t res_outcome_r;
  cell_op_t      res_op_r;
  fill_t         res_pos_r;
  cnt_t          res_cnt_r;
  fill_t         res_fill_r;

  logic                  out_valid_r;
  sktc_outcome_t         out_outcome_r;
  logic [POS_OUT_W-1:0]  out_pos_r;
  cnt_t                  out_cnt_r;
  logic [FILL_OUT_W-1:0] out_fill_r;

  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and cell commands
  always_comb begin
    state_nxt = state_r;
    upd_go    = 1'b0;
    cmd.cmp   = 1'b0;
    cmd.op    = CELL_OP_HOLD;
    cmd.tsel  = tsel_r;
    cmd.key   = key_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = ST_GRP;
      end
      ST_GRP: begin
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (!out_valid_r || out_chan.ready) begin
          upd_go    = 1'b1;
          cmd.op    = res_op_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r      <= in_chan.key;
      tsel_r     <= in_chan.table_select;
      fill_sel_r <= fill_r[in_chan.table_select];
    end
  end

  // row of cells, each fed by its lower neighbor
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    assign cell_in_range[i] = (FILL_W'(i) < fill_sel_r);
    if (i == 0) begin : g_head
      sktc_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_range   (cell_in_range[i]),
        .prev_entry (cell_entry[i]),
        .prev_lt    (1'b1),
        .entry      (cell_entry[i]),
        .lt         (cell_lt[i]),
        .eq         (cell_eq[i])
      );
    end else begin : g_body
      sktc_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_range   (cell_in_range[i]),
        .prev_entry (cell_entry[i-1]),
        .prev_lt    (cell_lt[i-1]),
        .entry      (cell_entry[i]),
        .lt         (cell_lt[i]),
        .eq         (cell_eq[i])
      );
    end
  end

  // group encoders, the last group padded with slots above the key
  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    logic [GRP_SIZE-1:0] g_lt;
    logic [GRP_SIZE-1:0] g_eq;
    cnt_t                g_cnt [GRP_SIZE];
    for (genvar j = 0; j < GRP_SIZE; j++) begin : g_tap
      if (g * GRP_SIZE + j < TABLE_DEPTH) begin : g_real
        assign g_lt[j]  = cell_lt[g*GRP_SIZE+j];
        assign g_eq[j]  = cell_eq[g*GRP_SIZE+j];
        assign g_cnt[j] = cell_entry[g*GRP_SIZE+j].cnt;
      end else begin : g_pad
        assign g_lt[j]  = 1'b0;
        assign g_eq[j]  = 1'b0;
        assign g_cnt[j] = '0;
      end
    end
    sktc_group u_grp (
      .clk (clk),
      .lt  (g_lt),
      .eq  (g_eq),
      .cnt (g_cnt),
      .sum (grp_sum[g])
    );
  end

  // combine group summaries: first group not wholly below the key
  always_comb begin
    sel_pos = FILL_W'(TABLE_DEPTH);
    sel_eq  = 1'b0;
    sel_cnt = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (!grp_sum[g].all_lt) begin
        sel_pos = FILL_W'(g * GRP_SIZE) + FILL_W'(grp_sum[g].loc);
      end
    end
    for (int g = 0; g < NUM_GRP; g++) begin
      sel_eq  = sel_eq | grp_sum[g].eq_any;
      sel_cnt = sel_cnt | grp_sum[g].cnt;
    end
  end

  assign sel_full = (fill_sel_r == FILL_W'(TABLE_DEPTH));

  // decide the outcome
  always_ff @(posedge clk) begin
    if (state_r == ST_SEL) begin
      if (sel_eq) begin
        res_outcome_r <= OUT_COUNTED;
        res_op_r      <= CELL_OP_COUNT;
        res_pos_r     <= sel_pos;
        res_cnt_r     <= (sel_cnt == CNT_MAX) ? CNT_MAX : sel_cnt + CNT_W'(1);
        res_fill_r    <= fill_sel_r;
      end else if (sel_full) begin
        res_outcome_r <= OUT_DROPPED;
        res_op_r      <= CELL_OP_HOLD;
        res_pos_r     <= '0;
        res_cnt_r     <= '0;
        res_fill_r    <= fill_sel_r;
      end else begin
        res_outcome_r <= OUT_INSERTED;
        res_op_r      <= CELL_OP_INSERT;
        res_pos_r     <= sel_pos;
        res_cnt_r     <= CNT_W'(1);
        res_fill_r    <= fill_sel_r + FILL_W'(1);
      end
    end
  end

  // fill counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r[0] <= '0;
      fill_r[1] <= '0;
    end else if (upd_go) begin
      fill_r[tsel_r] <= res_fill_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_outcome_r <= res_outcome_r;
      out_pos_r     <= POS_OUT_W'(res_pos_r);
      out_cnt_r     <= res_cnt_r;
      out_fill_r    <= FILL_OUT_W'(res_fill_r);
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.outcome        = out_outcome_r;
  assign out_chan.entry_position = out_pos_r;
  assign out_chan.entry_count    = out_cnt_r;
  assign out_chan.table_fill     = out_fill_r;

  `include "sorted_key_count_table_unit_defines.svh"

  // fill counts never pass the capacity
  `SKTC_ASSERT_SAME(a_fill_bound, 1'b1,
    (fill_r[0] <= FILL_W'(TABLE_DEPTH)) && (fill_r[1] <= FILL_W'(TABLE_DEPTH)),
    "fill count above capacity")

  // a dropped key reports zero position and count
  `SKTC_ASSERT_SAME(a_drop_zero, out_valid_r && (out_outcome_r == OUT_DROPPED),
    (out_pos_r == '0) && (out_cnt_r == '0), "dropped key with nonzero fields")

  // an inserted key starts at one
  `SKTC_ASSERT_SAME(a_ins_one, out_valid_r && (out_outcome_r == OUT_INSERTED),
    out_cnt_r == CNT_W'(1), "inserted key count not one")

  // an insert grows its table by exactly one
  `SKTC_ASSERT_NEXT(a_ins_grow, upd_go && (res_outcome_r == OUT_INSERTED),
    fill_r[tsel_r] == $past(fill_sel_r) + FILL_W'(1), "insert did not grow the fill")

  // only a full table drops
  `SKTC_ASSERT_SAME(a_drop_full, upd_go && (res_outcome_r == OUT_DROPPED),
    fill_sel_r == FILL_W'(TABLE_DEPTH), "drop from a table that is not full")

endmodule

[rtl/sktc_cell.sv]
// one table slot for both tables: key compare, count and shift from the lower neighbor
module sktc_cell import sktc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_cmd_t cmd,
  input  logic      in_range,
  input  entry_t    prev_entry,
  input  logic      prev_lt,
  output entry_t    entry,
  output logic      lt,
  output logic      eq
);

  key_t key_r [NUM_TABLES];
  cnt_t cnt_r [NUM_TABLES];
  logic lt_r;
  logic eq_r;

  // stored slot of the selected table
  assign entry.key = key_r[cmd.tsel];
  assign entry.cnt = cnt_r[cmd.tsel];
  assign lt        = lt_r;
  assign eq        = eq_r;

  // compare flags, held until the next compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (cmd.cmp) begin
      lt_r <= in_range && (entry.key < cmd.key);
      eq_r <= in_range && (entry.key == cmd.key);
    end
  end

  // count in place, or take the new key, or take the lower neighbor's slot
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CELL_OP_HOLD: begin
      end
      CELL_OP_COUNT: begin
        if (eq_r && (cnt_r[cmd.tsel] != CNT_MAX)) begin
          cnt_r[cmd.tsel] <= cnt_r[cmd.tsel] + CNT_W'(1);
        end
      end
      CELL_OP_INSERT: begin
        if (!lt_r) begin
          if (prev_lt) begin
            key_r[cmd.tsel] <= cmd.key;
            cnt_r[cmd.tsel] <= CNT_W'(1);
          end else begin
            key_r[cmd.tsel] <= prev_entry.key;
            cnt_r[cmd.tsel] <= prev_entry.cnt;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/sktc_group.sv]
// group encoder: first slot not below the key, match flag and matched count
module sktc_group import sktc_pkg::*; (
  input  logic                clk,
  input  logic [GRP_SIZE-1:0] lt,
  input  logic [GRP_SIZE-1:0] eq,
  input  cnt_t                cnt [GRP_SIZE],
  output grp_sum_t            sum
);

  grp_sum_t sum_nxt;
  grp_sum_t sum_r;

  // priority encode and or-reduce over the group
  always_comb begin
    sum_nxt.all_lt = &lt;
    sum_nxt.loc    = '0;
    sum_nxt.eq_any = |eq;
    sum_nxt.cnt    = '0;
    for (int j = GRP_SIZE - 1; j >= 0; j--) begin
      if (!lt[j]) begin
        sum_nxt.loc = LOC_W'(j);
      end
    end
    for (int j = 0; j < GRP_SIZE; j++) begin
      if (eq[j]) begin
        sum_nxt.cnt = sum_nxt.cnt | cnt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
  end

  assign sum = sum_r;

endmodule

[verif/sorted_key_count_table_unit_test.sv]
// testbench for the sorted key count table: directed, random and repeated-key transactions
module sorted_key_count_table_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sktc_pkg::*;

  localparam int IDLE_LIMIT     = 2000;
  localparam int SETTLE_TICKS   = 20;
  localparam int HAMMER_REPEATS = 100;

  // one predicted result
  typedef struct {
    sktc_outcome_t           outcome;
    logic [POS_OUT_W-1:0]    position;
    cnt_t                    count;
    logic [FILL_OUT_W-1:0]   fill;
  } tally_t;

  // mirror of both sorted tables plus the queue of predicted results
  class key_tally_board;
    key_t        keys [NUM_TABLES][TABLE_DEPTH];
    cnt_t        cnts [NUM_TABLES][TABLE_DEPTH];
    int unsigned fill [NUM_TABLES];
    tally_t      pending_tallies[$];
    int unsigned mismatch_count;
    int unsigned requests_seen;
    int unsigned counted_seen;
    int unsigned inserted_seen;
    int unsigned dropped_seen;

    task flag_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatch_count++;
      $display("[%0t] mismatch in %s: got %0h expected %0h", $time, what, got, want);
    endtask

    // count or insert one key, return the result the block should give
    function tally_t predict_update(logic tsel, key_t k);
      tally_t      r;
      int unsigned lo, hi, mid, n, i;
      n  = fill[tsel];
      lo = 0;
      hi = n;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (keys[tsel][mid] < k) lo = mid + 1;
        else hi = mid;
      end
      if (lo < n && keys[tsel][lo] == k) begin
        if (cnts[tsel][lo] != CNT_MAX) cnts[tsel][lo] = cnts[tsel][lo] + 1'b1;
        r.outcome  = OUT_COUNTED;
        r.position = POS_OUT_W'(lo);
        r.count    = cnts[tsel][lo];
      end else if (n >= TABLE_DEPTH) begin
        r.outcome  = OUT_DROPPED;
        r.position = '0;
        r.count    = '0;
      end else begin
        // shift higher entries up by one
        for (i = n; i > lo; i--) begin
          keys[tsel][i] = keys[tsel][i-1];
          cnts[tsel][i] = cnts[tsel][i-1];
        end
        keys[tsel][lo] = k;
        cnts[tsel][lo] = CNT_W'(1);
        n++;
        fill[tsel]     = n;
        r.outcome      = OUT_INSERTED;
        r.position     = POS_OUT_W'(lo);
        r.count        = CNT_W'(1);
      end
      r.fill = FILL_OUT_W'(n);
      return r;
    endfunction

    function void note_request(logic tsel, key_t k);
      tally_t r;
      r = predict_update(tsel, k);
      requests_seen++;
      case (r.outcome)
        OUT_COUNTED:  counted_seen++;
        OUT_INSERTED: inserted_seen++;
        default:      dropped_seen++;
      endcase
      pending_tallies.insert(pending_tallies.size(), r);
    endfunction

    task check_result(logic [OUTCOME_W-1:0] outcome, logic [POS_OUT_W-1:0] position,
                      cnt_t count, logic [FILL_OUT_W-1:0] tfill);
      tally_t want;
      if (pending_tallies.size() == 0) begin
        flag_mismatch("unrequested result outcome", outcome, 0);
        return;
      end
      want = pending_tallies.pop_front();
      if (outcome !== want.outcome) flag_mismatch("outcome", outcome, want.outcome);
      if (position !== want.position) flag_mismatch("entry_position", position, want.position);
      if (count !== want.count) flag_mismatch("entry_count", count, want.count);
      if (tfill !== want.fill) flag_mismatch("table_fill", tfill, want.fill);
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int unsigned idle_ticks;
  key_tally_board sb;

  sktc_in_if  in_if();
  sktc_out_if out_if();

  sorted_key_count_table_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transaction monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_request(in_if.table_select, in_if.key);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.outcome, out_if.entry_position, out_if.entry_count,
                      out_if.table_fill);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_ticks <= 0;
      else idle_ticks <= idle_ticks + 1;
      if (idle_ticks >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // result side back-pressure in short bursts
  initial begin
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(99) < 15) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_if.ready <= 1'b1;
      end
    end
  end

  // send one request and wait until it is taken
  task automatic send_key(input logic tsel, input key_t k);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(99) < 20) gap = $urandom_range(1, 5);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.table_select <= tsel;
    in_if.key          <= k;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // hold the request side until every predicted result has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_tallies.size() != 0) @(posedge clk);
  endtask

  // mostly fresh keys when filling, otherwise repeats and near neighbors
  function automatic key_t pick_key(logic tsel, int unsigned fresh_pct);
    key_t        k;
    int unsigned n;
    n = sb.fill[tsel];
    if (n != 0 && $urandom_range(99) >= fresh_pct)
      return sb.keys[tsel][$urandom_range(n - 1)];
    case ($urandom_range(19))
      0: k = '0;
      1: k = '1;
      2: k = key_t'($urandom_range(15));
      3: k = (n != 0) ? sb.keys[tsel][$urandom_range(n - 1)] + 1'b1 : key_t'(1);
      4: k = (n != 0) ? sb.keys[tsel][$urandom_range(n - 1)] - 1'b1 : '1;
      default: k = {$urandom, $urandom};
    endcase
    return k;
  endfunction

  initial begin
    int   i;
    logic tsel;
    key_t sat_key;

    sb = new();
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.table_select <= 1'b0;
    in_if.key          <= '0;
    idle_ticks         <= 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme keys, inserts at front, middle and end, repeats, both tables
    send_key(1'b0, key_t'(5));
    send_key(1'b0, key_t'(5));
    send_key(1'b0, '0);
    send_key(1'b0, '1);
    send_key(1'b0, 64'h8000_0000_0000_0000);
    send_key(1'b0, key_t'(3));
    send_key(1'b0, key_t'(6));
    send_key(1'b0, '1);
    send_key(1'b0, '0);
    send_key(1'b1, '1);
    send_key(1'b1, key_t'(5));
    send_key(1'b1, '0);
    send_key(1'b1, '0);
    send_key(1'b0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_key(1'b1, 64'hAAAA_AAAA_AAAA_AAAA);
    send_key(1'b1, 64'h5555_5555_5555_5555);
    send_key(1'b0, key_t'(4));
    send_key(1'b1, 64'hFFFF_FFFF_FFFF_FFFE);
    drain_results();

    // fill table 0 to capacity, table 1 grows slowly alongside
    i = 0;
    while (sb.fill[0] < TABLE_DEPTH) begin
      if (i % 100 == 0) calm = ($urandom_range(3) == 0);
      tsel = ($urandom_range(99) < 90) ? 1'b0 : 1'b1;
      send_key(tsel, pick_key(tsel, 95));
      i++;
    end
    drain_results();

    // full table 0: absent keys dropped, present keys counted, mixed with table 1 requests
    for (i = 0; i < 400; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(3) == 0);
      tsel = 1'($urandom_range(1));
      send_key(tsel, pick_key(tsel, 50));
    end
    drain_results();

    // one key repeated back to back, no idling from here on
    calm    = 1'b1;
    sat_key = {$urandom, $urandom};
    for (i = 0; i < HAMMER_REPEATS; i++) send_key(1'b1, sat_key);
    in_if.valid <= 1'b0;

    while (sb.pending_tallies.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (sb.pending_tallies.size() != 0)
      sb.flag_mismatch("results never delivered", 0, sb.pending_tallies.size());

    $display("run: %0d requests, %0d counted, %0d inserted, %0d dropped",
             sb.requests_seen, sb.counted_seen, sb.inserted_seen, sb.dropped_seen);
    $display("run: table 0 filled to %0d, table 1 at %0d, one key counted back to back",
             sb.fill[0], sb.fill[1]);
    if (sb.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
